/* hw/rtl/tmdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode display controller package
// Shared geometry constants, operation codes, payload structs and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tmdc_pkg;

    // Display geometry
    localparam int TEXT_ROWS     = 8;
    localparam int TEXT_COLS     = 16;
    localparam int SCREEN_WIDTH  = 96;
    localparam int SCREEN_HEIGHT = 64;
    localparam int GLYPH_W       = 6;
    localparam int GLYPH_H       = 8;
    localparam int NUM_CELLS     = TEXT_ROWS * TEXT_COLS;
    localparam int CELL_AW       = $clog2(NUM_CELLS);
    localparam int FONT_ROWS     = 256 * GLYPH_H;
    localparam int GLYPH_AW      = $clog2(FONT_ROWS);
    localparam int BM_AW         = $clog2(SCREEN_HEIGHT);

    // Scroll copy: every row but the first moves up by one row
    localparam int SCROLL_LEN    = (TEXT_ROWS - 1) * TEXT_COLS;
    localparam int SCNT_W        = $clog2(SCROLL_LEN + 1);

    // x / 6 as (x * 43) >> 8, exact for x below 128
    localparam int DIV6_MUL      = 43;
    localparam int DIV6_SHIFT    = 8;

    // Leftmost glyph pixel sits in the MSB of a font row
    localparam logic [2:0] GLYPH_MSB = 3'd7;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_INVERT = 2'd2;

    localparam logic [31:0] FG_COLOR_RESET = 32'hFF78C299;
    localparam logic [31:0] BG_COLOR_RESET = 32'hFF5C4530;

    // Operation codes
    typedef enum logic [2:0] {
        MODE_CELL    = 3'd0,
        MODE_FONT    = 3'd1,
        MODE_PIXEL   = 3'd2,
        MODE_BITMAP  = 3'd3,
        MODE_READ    = 3'd4,
        MODE_PUTCHAR = 3'd5,
        MODE_NEWLINE = 3'd6,
        MODE_CLEAR   = 3'd7
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  cell_row;
        logic [3:0]  cell_col;
        logic [7:0]  char_code;
        logic        cell_invert;
        logic [2:0]  glyph_row;
        logic [7:0]  glyph_bits;
        logic [5:0]  pix_y;
        logic [6:0]  pix_x;
        logic        pixel_on;
    } in_t;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic        pixel_lit;
        logic [2:0]  cursor_row_now;
        logic [3:0]  cursor_col_now;
        logic        text_mode_on;
    } out_t;

    typedef struct packed {
        logic [7:0] code;
        logic       inv;
    } cell_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_BM_WR,
        ST_GLYPH_RD,
        ST_SCROLL,
        ST_RESP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic item_load;
        logic cell_wr_item;
        logic cell_wr_cursor;
        logic cell_rd_pixel;
        logic clear_cells;
        logic glyph_wr;
        logic glyph_rd;
        logic bm_rd;
        logic bm_wr;
        logic text_on;
        logic text_off;
        logic cursor_put;
        logic cursor_newline;
        logic scroll_start;
        logic scroll_step;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  pix_in_range;
        logic  text_mode;
        logic  cursor_last_row;
        logic  cursor_last_col;
        logic  scroll_done;
        logic  out_free;
    } status_t;

endpackage

/* hw/rtl/tmdc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode display controller sequencer
// Accepts one transaction at a time, steps the datapath through the memory
// accesses of its operation and hands the result to the output register.
// ----------------------------------------------------------------------------
module tmdc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tmdc_pkg::status_t status,
    output tmdc_pkg::cmd_t    cmd
);
    import tmdc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (status.mode)
                    MODE_CELL: begin
                        cmd.cell_wr_item = 1'b1;
                        cmd.text_on      = 1'b1;
                        done             = 1'b1;
                    end
                    MODE_FONT: begin
                        cmd.glyph_wr = 1'b1;
                        done         = 1'b1;
                    end
                    MODE_PIXEL: begin
                        if (status.pix_in_range) begin
                            cmd.bm_rd  = 1'b1;
                            state_next = ST_BM_WR;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    MODE_BITMAP: begin
                        cmd.text_off = 1'b1;
                        done         = 1'b1;
                    end
                    MODE_READ: begin
                        if (!status.pix_in_range) begin
                            done = 1'b1;
                        end else if (status.text_mode) begin
                            cmd.cell_rd_pixel = 1'b1;
                            state_next        = ST_GLYPH_RD;
                        end else begin
                            cmd.bm_rd  = 1'b1;
                            state_next = ST_RESP;
                        end
                    end
                    MODE_PUTCHAR: begin
                        cmd.cell_wr_cursor = 1'b1;
                        cmd.text_on        = 1'b1;
                        cmd.cursor_put     = 1'b1;
                        if (status.cursor_last_col && status.cursor_last_row) begin
                            cmd.scroll_start = 1'b1;
                            state_next       = ST_SCROLL;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    MODE_NEWLINE: begin
                        cmd.cursor_newline = 1'b1;
                        if (status.cursor_last_row) begin
                            cmd.scroll_start = 1'b1;
                            state_next       = ST_SCROLL;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    MODE_CLEAR: begin
                        cmd.clear_cells = 1'b1;
                        cmd.text_on     = 1'b1;
                        done            = 1'b1;
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
            ST_BM_WR: begin
                cmd.bm_wr = 1'b1;
                done      = 1'b1;
            end
            ST_GLYPH_RD: begin
                cmd.glyph_rd = 1'b1;
                state_next   = ST_RESP;
            end
            ST_SCROLL: begin
                cmd.scroll_step = 1'b1;
                if (status.scroll_done) begin
                    done = 1'b1;
                end
            end
            ST_RESP: begin
                done = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Hand the result over, or hold it back until the output slot frees
        if (done) begin
            if (status.out_free) begin
                cmd.out_load = 1'b1;
                state_next   = ST_IDLE;
            end else begin
                state_next = ST_RESP;
            end
        end
    end

`ifndef SYNTHESIS
    // An accepted transaction is always dispatched on the next cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction not dispatched");
`endif

endmodule

/* hw/rtl/tmdc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode display controller datapath
// Holds the configuration, transaction register, cell/font/bitmap stores,
// console cursor, scroll copy counter and the result output register.
// ----------------------------------------------------------------------------
module tmdc_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tmdc_pkg::in_t                        s_data,
    input  logic                                 cfg_wr_en,
    input  logic [tmdc_pkg::CFG_IDX_W-1:0]       cfg_wr_idx,
    input  logic [tmdc_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  tmdc_pkg::cmd_t                       cmd,
    output tmdc_pkg::status_t                    status,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output tmdc_pkg::out_t                       m_data
);
    import tmdc_pkg::*;

    // Configuration
    logic [31:0] fg_color_reg;
    logic [31:0] bg_color_reg;
    logic        global_invert_reg;

    // Transaction and console state
    in_t         item_reg;
    logic [2:0]  cursor_row_reg;
    logic [2:0]  cursor_row_next;
    logic [3:0]  cursor_col_reg;
    logic [3:0]  cursor_col_next;
    logic        text_mode_reg;
    logic        text_mode_next;
    logic [SCNT_W-1:0] scnt_reg;
    logic [SCNT_W-1:0] scnt_next;

    // Cell store
    cell_t                cell_mem [NUM_CELLS];
    logic [NUM_CELLS-1:0] cell_vld_reg;
    cell_t                cell_rdata_reg;
    logic                 cell_rvld_reg;
    cell_t                cell_eff;
    logic                 cell_we;
    logic [CELL_AW-1:0]   cell_waddr;
    cell_t                cell_wdata;
    logic                 cell_re;
    logic [CELL_AW-1:0]   cell_raddr;

    // Font store
    logic [7:0]           glyph_mem [FONT_ROWS];
    logic [7:0]           glyph_rdata_reg;
    logic [GLYPH_AW-1:0]  glyph_waddr;
    logic [GLYPH_AW-1:0]  glyph_raddr;

    // Bitmap store, one 96-bit word per pixel row
    logic [SCREEN_WIDTH-1:0]  bm_mem [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] bm_vld_reg;
    logic [SCREEN_WIDTH-1:0]  bm_rdata_reg;
    logic                     bm_rvld_reg;
    logic [SCREEN_WIDTH-1:0]  bm_eff;
    logic [SCREEN_WIDTH-1:0]  bm_mod;

    // Pixel addressing and result
    logic [12:0] div6_prod;
    logic [3:0]  cell_x;
    logic [6:0]  cell_x6;
    logic [2:0]  glyph_x;
    logic        pix_in_range;
    logic        text_lit;
    logic        bm_lit;
    logic        lit;
    out_t        result;
    out_t        m_data_reg;
    logic        m_valid_reg;
    logic        out_free;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_color_reg      <= FG_COLOR_RESET;
            bg_color_reg      <= BG_COLOR_RESET;
            global_invert_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_idx)
                CFG_FG_COLOR:      fg_color_reg      <= cfg_wr_data;
                CFG_BG_COLOR:      bg_color_reg      <= cfg_wr_data;
                CFG_GLOBAL_INVERT: global_invert_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Capture the transaction
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_reg <= s_data;
        end
    end

    // Cursor, text mode and scroll counter updates
    always_comb begin
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        text_mode_next  = text_mode_reg;
        scnt_next       = scnt_reg;
        if (cmd.cursor_put) begin
            if (cursor_col_reg == 4'(TEXT_COLS - 1)) begin
                cursor_col_next = '0;
                if (cursor_row_reg != 3'(TEXT_ROWS - 1)) begin
                    cursor_row_next = cursor_row_reg + 3'd1;
                end
            end else begin
                cursor_col_next = cursor_col_reg + 4'd1;
            end
        end
        if (cmd.cursor_newline) begin
            cursor_col_next = '0;
            if (cursor_row_reg != 3'(TEXT_ROWS - 1)) begin
                cursor_row_next = cursor_row_reg + 3'd1;
            end
        end
        if (cmd.clear_cells) begin
            cursor_row_next = '0;
            cursor_col_next = '0;
        end
        if (cmd.text_on) begin
            text_mode_next = 1'b1;
        end
        if (cmd.text_off) begin
            text_mode_next = 1'b0;
        end
        // Hold the counter at the copy length once the last cell has moved
        if (cmd.scroll_start) begin
            scnt_next = '0;
        end else if (cmd.scroll_step && (scnt_reg != SCNT_W'(SCROLL_LEN))) begin
            scnt_next = scnt_reg + SCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            text_mode_reg  <= 1'b0;
            scnt_reg       <= '0;
        end else begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            text_mode_reg  <= text_mode_next;
            scnt_reg       <= scnt_next;
        end
    end

    // Pixel column to cell column and glyph column
    assign div6_prod    = 13'(item_reg.pix_x) * 13'(DIV6_MUL);
    assign cell_x       = div6_prod[DIV6_SHIFT +: 4];
    assign cell_x6      = 7'({cell_x, 2'b00}) + 7'({cell_x, 1'b0});
    assign glyph_x      = 3'(item_reg.pix_x - cell_x6);
    assign pix_in_range = item_reg.pix_x < 7'(SCREEN_WIDTH);

    // Cell store port selection: scroll copy, item write, cursor write
    assign cell_eff = cell_rvld_reg ? cell_rdata_reg : '0;

    always_comb begin
        cell_we    = 1'b0;
        cell_waddr = '0;
        cell_wdata = '0;
        cell_re    = 1'b0;
        cell_raddr = '0;
        if (cmd.scroll_step && (scnt_reg != '0)) begin
            cell_we    = 1'b1;
            cell_waddr = CELL_AW'(scnt_reg - SCNT_W'(1));
            cell_wdata = cell_eff;
        end else if (cmd.cell_wr_item) begin
            cell_we    = 1'b1;
            cell_waddr = {item_reg.cell_row, item_reg.cell_col};
            cell_wdata = '{code: item_reg.char_code, inv: item_reg.cell_invert};
        end else if (cmd.cell_wr_cursor) begin
            cell_we    = 1'b1;
            cell_waddr = {cursor_row_reg, cursor_col_reg};
            cell_wdata = '{code: item_reg.char_code, inv: 1'b0};
        end
        if (cmd.scroll_step && (scnt_reg != SCNT_W'(SCROLL_LEN))) begin
            cell_re    = 1'b1;
            cell_raddr = CELL_AW'(scnt_reg + SCNT_W'(TEXT_COLS));
        end else if (cmd.cell_rd_pixel) begin
            cell_re    = 1'b1;
            cell_raddr = {item_reg.pix_y[5:3], cell_x};
        end
    end

    // Cell memory
    always_ff @(posedge aclk) begin
        if (cell_we) begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        if (cell_re) begin
            cell_rdata_reg <= cell_mem[cell_raddr];
            cell_rvld_reg  <= cell_vld_reg[cell_raddr];
        end
    end

    // Cell valid bits: an unwritten cell reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_vld_reg <= '0;
        end else if (cmd.clear_cells) begin
            cell_vld_reg <= '0;
        end else if (cell_we) begin
            cell_vld_reg[cell_waddr] <= 1'b1;
        end
    end

    // Font memory
    assign glyph_waddr = {item_reg.char_code, item_reg.glyph_row};
    assign glyph_raddr = {cell_eff.code, item_reg.pix_y[2:0]};

    always_ff @(posedge aclk) begin
        if (cmd.glyph_wr) begin
            glyph_mem[glyph_waddr] <= item_reg.glyph_bits;
        end
        if (cmd.glyph_rd) begin
            glyph_rdata_reg <= glyph_mem[glyph_raddr];
        end
    end

    // Bitmap row read-modify-write
    assign bm_eff = bm_rvld_reg ? bm_rdata_reg : '0;

    always_comb begin
        for (int b = 0; b < SCREEN_WIDTH; b++) begin
            bm_mod[b] = (7'(b) == item_reg.pix_x) ? item_reg.pixel_on : bm_eff[b];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.bm_wr) begin
            bm_mem[item_reg.pix_y] <= bm_mod;
        end
        if (cmd.bm_rd) begin
            bm_rdata_reg <= bm_mem[item_reg.pix_y];
            bm_rvld_reg  <= bm_vld_reg[item_reg.pix_y];
        end
    end

    // Bitmap row valid bits: an unwritten row reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bm_vld_reg <= '0;
        end else if (cmd.bm_wr) begin
            bm_vld_reg[item_reg.pix_y] <= 1'b1;
        end
    end

    // Lit state of the addressed pixel
    assign text_lit = glyph_rdata_reg[GLYPH_MSB - glyph_x] ^ global_invert_reg ^ cell_eff.inv;
    assign bm_lit   = bm_eff[item_reg.pix_x];
    assign lit      = (item_reg.mode == MODE_READ) && pix_in_range &&
                      (text_mode_reg ? text_lit : bm_lit);

    always_comb begin
        result.pixel_color    = '0;
        result.pixel_lit      = lit;
        result.cursor_row_now = cursor_row_next;
        result.cursor_col_now = cursor_col_next;
        result.text_mode_on   = text_mode_next;
        if (item_reg.mode == MODE_READ) begin
            result.pixel_color = lit ? fg_color_reg : bg_color_reg;
        end
    end

    // Output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Status back to the controller
    assign status.mode            = item_reg.mode;
    assign status.pix_in_range    = pix_in_range;
    assign status.text_mode       = text_mode_reg;
    assign status.cursor_last_row = cursor_row_reg == 3'(TEXT_ROWS - 1);
    assign status.cursor_last_col = cursor_col_reg == 4'(TEXT_COLS - 1);
    assign status.scroll_done     = scnt_reg == SCNT_W'(SCROLL_LEN);
    assign status.out_free        = out_free;

`ifndef SYNTHESIS
    a_scnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        scnt_reg <= SCNT_W'(SCROLL_LEN))
        else $error("scroll counter overran the copy length");

    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scroll_step |-> (cursor_row_reg == 3'(TEXT_ROWS - 1)))
        else $error("scroll running with cursor off the last row");

    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken result");
`endif

endmodule

/* hw/rtl/text_mode_display_controller_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode display controller core
// Monochrome 96x64 display with a 16x8 grid of 6x8 character cells, a
// loadable font, a pixel bitmap and a scrolling console cursor.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and each gives one result. Cell, font
// and mode writes, newline and clear without scrolling, and put-character
// without scrolling finish in the execute state; a bitmap pixel write reads
// its bitmap row and writes it back, a bitmap-mode pixel read reads the row,
// and a text-mode pixel read does a cell read followed by a font read. A
// put-character or newline that leaves the last row scrolls the grid by
// copying 112 cells through the cell store, one a cycle. A result waiting at
// the output holds up the block only once the next transaction has finished.
// The cells and bitmap read as zero straight after reset; the font must be
// loaded before use. Configuration is written through cfg_wr_en/cfg_wr_idx/
// cfg_wr_data; the user must write it while the block is idle, which is not
// enforced by the block: index 0 lit colour, 1 unlit colour, 2 global invert.
module text_mode_display_controller_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tmdc_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tmdc_pkg::out_t                   m_data,
    input  logic                             cfg_wr_en,
    input  logic [tmdc_pkg::CFG_IDX_W-1:0]   cfg_wr_idx,
    input  logic [tmdc_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import tmdc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    tmdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Stores, cursor and result register
    tmdc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
